// ===== hw/rtl/hrht_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP request head tokenizer package
// Shared result type, part and status codes, and the method and version
// spellings used by the byte classifier.
// ----------------------------------------------------------------------------
package hrht_pkg;

    // Character codes.
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    // Part tags carried on each result.
    localparam logic [3:0] PART_METHOD   = 4'd0;
    localparam logic [3:0] PART_PATH     = 4'd1;
    localparam logic [3:0] PART_QUERY    = 4'd2;
    localparam logic [3:0] PART_VERSION  = 4'd3;
    localparam logic [3:0] PART_HNAME    = 4'd4;
    localparam logic [3:0] PART_HVALUE   = 4'd5;
    localparam logic [3:0] PART_SEP      = 4'd6;
    localparam logic [3:0] PART_LINE_END = 4'd7;
    localparam logic [3:0] PART_UNPARSED = 4'd8;

    // Status codes.
    localparam logic [2:0] ST_ONGOING  = 3'd0;
    localparam logic [2:0] ST_REQ_OK   = 3'd1;
    localparam logic [2:0] ST_HDR_DONE = 3'd2;
    localparam logic [2:0] ST_HEAD_END = 3'd3;
    localparam logic [2:0] ST_REJECT   = 3'd4;

    // Version codes.
    localparam logic [1:0] VER_NONE = 2'd0;
    localparam logic [1:0] VER_1_0  = 2'd1;
    localparam logic [1:0] VER_1_1  = 2'd2;

    // Method names, left justified in six byte slots, and their lengths.
    localparam int NUM_METHODS = 5;
    localparam logic [47:0] METHOD_STR [NUM_METHODS] = '{
        {"GET", 24'h0}, {"POST", 16'h0}, {"HEAD", 16'h0}, {"PUT", 24'h0}, "DELETE"
    };
    localparam logic [2:0] METHOD_LEN [NUM_METHODS] = '{3'd3, 3'd4, 3'd4, 3'd3, 3'd6};

    // Common prefix of both accepted versions and the final digit of each.
    localparam logic [55:0] VERSION_PREFIX = "HTTP/1.";
    localparam logic [3:0]  VERSION_LEN    = 4'd8;
    localparam logic [7:0]  VERSION_DIGIT [2] = '{"0", "1"};

    // Result queue depth.
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);

    typedef enum logic [1:0] {
        PH_REQ_LINE = 2'd0,
        PH_HEADERS  = 2'd1,
        PH_COMPLETE = 2'd2,
        PH_REJECTED = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        LP_METHOD  = 2'd0,
        LP_PATH    = 2'd1,
        LP_QUERY   = 2'd2,
        LP_VERSION = 2'd3
    } t_line_part;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [3:0] part;
        logic [2:0] method_code;
        logic [1:0] version_code;
        logic [2:0] status;
        logic       last;
    } t_result;

    // Results produced by one accepted transaction.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_step_out;

endpackage

// ===== hw/rtl/hrht_ifs.sv =====
// ----------------------------------------------------------------------------
// HTTP request head tokenizer channels
// Valid/ready channels for the request byte stream and the tagged byte stream.
// ----------------------------------------------------------------------------
interface hrht_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface hrht_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic [3:0] part;
    logic [2:0] method_code;
    logic [1:0] version_code;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output byte_out, output part, output method_code,
                    output version_code, output status, output last, input ready);
    modport sink   (input valid, input byte_out, input part, input method_code,
                    input version_code, input status, input last, output ready);
endinterface

// ===== hw/rtl/hrht_core.sv =====
// ----------------------------------------------------------------------------
// HTTP request head tokenizer core
// Parser state register and the single-pass classification of one byte into
// zero, one or two tagged results.
// ----------------------------------------------------------------------------
module hrht_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_kind,
    input  logic [7:0]         i_data_byte,
    output hrht_pkg::t_step_out o_step
);
    import hrht_pkg::*;

    typedef struct packed {
        t_phase     phase;
        t_line_part line_part;
        logic [4:0] method_cand;
        logic [2:0] method_len;
        logic [1:0] version_match;
        logic [3:0] version_len;
        logic       colon_seen;
        logic       cr_pending;
        logic [2:0] method_held;
    } t_state;

    typedef struct packed {
        t_state  st;
        t_result res;
        logic    emit;
    } t_cres;

    localparam t_state STATE_RESET = '{
        phase: PH_REQ_LINE, line_part: LP_METHOD, method_cand: 5'h1F,
        method_len: 3'd0, version_match: 2'b11, version_len: 4'd0,
        colon_seen: 1'b0, cr_pending: 1'b0, method_held: 3'd0
    };

    t_state r_state;
    t_state n_state;

    function automatic logic [7:0] method_char(input int idx, input logic [2:0] pos);
        logic [47:0] s;
        logic [7:0]  c;
        s = METHOD_STR[idx];
        case (pos)
            3'd0:    c = s[47:40];
            3'd1:    c = s[39:32];
            3'd2:    c = s[31:24];
            3'd3:    c = s[23:16];
            3'd4:    c = s[15:8];
            3'd5:    c = s[7:0];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] version_char(input int idx, input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = VERSION_PREFIX[55:48];
            3'd1:    c = VERSION_PREFIX[47:40];
            3'd2:    c = VERSION_PREFIX[39:32];
            3'd3:    c = VERSION_PREFIX[31:24];
            3'd4:    c = VERSION_PREFIX[23:16];
            3'd5:    c = VERSION_PREFIX[15:8];
            3'd6:    c = VERSION_PREFIX[7:0];
            default: c = VERSION_DIGIT[idx];
        endcase
        return c;
    endfunction

    // Tag one content byte of the current line; always gives one result.
    function automatic t_cres content_f(input t_state s, input logic [7:0] b);
        t_cres      r;
        logic [4:0] live;
        logic [1:0] vlive;
        logic [2:0] code;
        r           = '0;
        r.st        = s;
        r.emit      = 1'b1;
        r.res.byte_out = b;
        r.res.status   = ST_ONGOING;
        live  = '0;
        vlive = '0;
        code  = '0;
        if (s.phase == PH_HEADERS) begin
            if (s.colon_seen) begin
                r.res.part = PART_HVALUE;
            end else if (b == CH_COLON) begin
                r.st.colon_seen = 1'b1;
                r.res.part      = PART_SEP;
            end else begin
                r.res.part = PART_HNAME;
            end
        end else begin
            case (s.line_part)
                LP_METHOD: begin
                    if (b == CH_SP) begin
                        for (int i = 0; i < NUM_METHODS; i++) begin
                            if (s.method_cand[i] && METHOD_LEN[i] == s.method_len) begin
                                code = 3'(i + 1);
                            end
                        end
                        if (code == 3'd0) begin
                            r.res.part   = PART_UNPARSED;
                            r.res.status = ST_REJECT;
                            r.st.phase   = PH_REJECTED;
                        end else begin
                            r.st.method_held = code;
                            r.st.line_part   = LP_PATH;
                            r.res.part       = PART_SEP;
                        end
                    end else begin
                        for (int i = 0; i < NUM_METHODS; i++) begin
                            if (s.method_cand[i] && s.method_len < METHOD_LEN[i]
                                && method_char(i, s.method_len) == b) begin
                                live[i] = 1'b1;
                            end
                        end
                        r.st.method_cand = live;
                        if (live == 5'd0) begin
                            r.res.part   = PART_UNPARSED;
                            r.res.status = ST_REJECT;
                            r.st.phase   = PH_REJECTED;
                        end else begin
                            r.st.method_len = s.method_len + 3'd1;
                            r.res.part      = PART_METHOD;
                        end
                    end
                end
                LP_PATH, LP_QUERY: begin
                    if (b == CH_SP) begin
                        r.st.line_part = LP_VERSION;
                        r.res.part     = PART_SEP;
                    end else if (b == CH_QMARK && s.line_part == LP_PATH) begin
                        r.st.line_part = LP_QUERY;
                        r.res.part     = PART_SEP;
                    end else begin
                        r.res.part = {2'b00, s.line_part};
                    end
                end
                default: begin
                    for (int i = 0; i < 2; i++) begin
                        if (s.version_match[i] && s.version_len < VERSION_LEN
                            && version_char(i, s.version_len[2:0]) == b) begin
                            vlive[i] = 1'b1;
                        end
                    end
                    r.st.version_match = vlive;
                    if (vlive == 2'd0) begin
                        r.res.part   = PART_UNPARSED;
                        r.res.status = ST_REJECT;
                        r.st.phase   = PH_REJECTED;
                    end else begin
                        r.st.version_len = s.version_len + 4'd1;
                        r.res.part       = PART_VERSION;
                    end
                end
            endcase
        end
        r.res.method_code = r.st.method_held;
        return r;
    endfunction

    // A fresh byte: unparsed after the head, held if CR, else content.
    function automatic t_cres take_byte_f(input t_state s, input logic [7:0] b);
        t_cres r;
        r = '0;
        r.st = s;
        if (s.phase == PH_COMPLETE || s.phase == PH_REJECTED) begin
            r.emit             = 1'b1;
            r.res.byte_out     = b;
            r.res.part         = PART_UNPARSED;
            r.res.status       = ST_ONGOING;
            r.res.method_code  = s.method_held;
        end else if (b == CH_CR) begin
            r.st.cr_pending = 1'b1;
        end else begin
            r = content_f(s, b);
        end
        return r;
    endfunction

    always_comb begin
        t_state     s;
        t_cres      c0;
        t_cres      c1;
        logic [1:0] vcode;
        s      = r_state;
        c0     = '0;
        c1     = '0;
        vcode  = VER_NONE;
        o_step = '0;
        if (i_kind) begin
            n_state = STATE_RESET;
        end else if ((s.phase == PH_REQ_LINE || s.phase == PH_HEADERS) && s.cr_pending) begin
            s.cr_pending = 1'b0;
            if (i_data_byte == CH_LF) begin
                // CR LF line end: two results, line status on the LF.
                o_step.count = 2'd2;
                o_step.res0  = '{byte_out: CH_CR, part: PART_LINE_END,
                                 method_code: s.method_held, version_code: VER_NONE,
                                 status: ST_ONGOING, last: 1'b0};
                o_step.res1  = '{byte_out: CH_LF, part: PART_LINE_END,
                                 method_code: s.method_held, version_code: VER_NONE,
                                 status: ST_ONGOING, last: 1'b1};
                if (s.phase == PH_REQ_LINE) begin
                    if (s.line_part == LP_VERSION && s.version_len == VERSION_LEN
                        && s.version_match != 2'd0) begin
                        vcode = s.version_match[1] ? VER_1_1 : VER_1_0;
                        s.phase      = PH_HEADERS;
                        s.colon_seen = 1'b0;
                        o_step.res1.status       = ST_REQ_OK;
                        o_step.res1.version_code = vcode;
                    end else begin
                        s.phase = PH_REJECTED;
                        o_step.res1.status = ST_REJECT;
                    end
                end else if (s.colon_seen) begin
                    s.colon_seen = 1'b0;
                    o_step.res1.status = ST_HDR_DONE;
                end else begin
                    s.phase = PH_COMPLETE;
                    o_step.res1.status = ST_HEAD_END;
                end
                n_state = s;
            end else begin
                // Lone CR is released as content, then the new byte follows.
                c0 = content_f(s, CH_CR);
                c1 = take_byte_f(c0.st, i_data_byte);
                n_state     = c1.st;
                o_step.res0 = c0.res;
                if (c1.emit) begin
                    o_step.count     = 2'd2;
                    o_step.res1      = c1.res;
                    o_step.res1.last = 1'b1;
                end else begin
                    o_step.count     = 2'd1;
                    o_step.res0.last = 1'b1;
                end
            end
        end else begin
            s.cr_pending = 1'b0;
            c0 = take_byte_f(s, i_data_byte);
            n_state          = c0.st;
            o_step.res0      = c0.res;
            o_step.res0.last = 1'b1;
            o_step.count     = c0.emit ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (i_accept) begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/hrht_rfifo.sv =====
// ----------------------------------------------------------------------------
// HTTP request head tokenizer result queue
// Small queue that takes up to two results per cycle and releases one.
// ----------------------------------------------------------------------------
module hrht_rfifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_wr_count,
    input  hrht_pkg::t_result i_wr_res0,
    input  hrht_pkg::t_result i_wr_res1,
    input  logic              i_rd,
    output logic              o_room2,
    output logic              o_valid,
    output hrht_pkg::t_result o_res
);
    import hrht_pkg::*;

    t_result          r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wr_ptr;
    logic [RQ_AW-1:0] r_rd_ptr;
    logic [RQ_AW:0]   r_count;
    logic [RQ_AW-1:0] n_wr_ptr;
    logic [RQ_AW-1:0] n_rd_ptr;
    logic [RQ_AW:0]   n_count;
    logic             rd_en;

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd_ptr];
    assign o_room2 = (r_count <= (RQ_AW + 1)'(RQ_DEPTH - 2));
    assign rd_en   = i_rd && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr + RQ_AW'(i_wr_count);
        n_rd_ptr = r_rd_ptr + RQ_AW'(rd_en);
        n_count  = r_count + (RQ_AW + 1)'(i_wr_count) - (RQ_AW + 1)'(rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_wr_res0;
        end
        if (i_wr_count == 2'd2) begin
            r_mem[r_wr_ptr + RQ_AW'(1)] <= i_wr_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== hw/rtl/http_request_head_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// HTTP request head tokenizer
// Tags every byte of an HTTP/1.x request head with the part it belongs to.
// ----------------------------------------------------------------------------
// Request bytes enter on i_req one per transaction and leave on o_tok tagged
// as method, path, query, version, header name, header value, separator, line
// end or unparsed, together with the method code, the version code and a line
// status. A transaction with kind set restarts the parser for a new request
// and gives no output. A CR is held back until the next byte shows whether it
// starts a CR LF line end, so a byte can give zero, one or two output
// transactions; last marks the final one that a byte causes. The block takes a
// byte in every cycle while the queue has room for two results: each byte is
// classified in one pass of logic at the moment it is accepted, and its
// results land in a four-entry result queue that feeds o_tok. i_req.ready
// stays high while the queue has room for two results, so with a sink that
// never stalls the throughput is one byte per cycle. A held CR gives nothing
// in its own cycle and comes out together with the result of the byte after
// it, so line ends leave the rate unchanged. The results of a byte reach the
// head of o_tok in the cycle after the byte is accepted when nothing waits
// ahead of them; results already queued in front leave first. There are no
// configuration registers and no clearing pass after reset.
// ----------------------------------------------------------------------------
module http_request_head_tokenizer_top (
    input logic i_clk,
    input logic i_rst_n,
    hrht_in_if.sink    i_req,
    hrht_out_if.source o_tok
);
    import hrht_pkg::*;

    t_step_out step;
    t_result   head;
    logic      accept;
    logic      room2;
    logic      head_valid;

    // A byte is taken only when the queue can absorb both possible results.
    assign i_req.ready = room2;
    assign accept      = i_req.valid && room2;

    // Parser state and per-byte classification.
    hrht_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_kind      (i_req.kind),
        .i_data_byte (i_req.data_byte),
        .o_step      (step)
    );

    // Result queue between the parser and the output channel.
    hrht_rfifo u_rfifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_count (accept ? step.count : 2'd0),
        .i_wr_res0  (step.res0),
        .i_wr_res1  (step.res1),
        .i_rd       (o_tok.ready),
        .o_room2    (room2),
        .o_valid    (head_valid),
        .o_res      (head)
    );

    assign o_tok.valid        = head_valid;
    assign o_tok.byte_out     = head.byte_out;
    assign o_tok.part         = head.part;
    assign o_tok.method_code  = head.method_code;
    assign o_tok.version_code = head.version_code;
    assign o_tok.status       = head.status;
    assign o_tok.last         = head.last;

endmodule

// ===== bench/tb_http_request_head_tokenizer_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the HTTP request head tokenizer
// Feeds request bytes and restart transactions through the block, predicts the
// tag stream for every byte, and checks each tagged byte field by field.
// ----------------------------------------------------------------------------

import hrht_pkg::*;

// Transaction kinds on the request channel.
localparam logic KIND_DATA    = 1'b0;
localparam logic KIND_RESTART = 1'b1;

// Predicts the tagged bytes of a request stream and checks the block's output
// against them in order.
class tag_scoreboard;
    localparam logic [2:0] NO_METHOD = 3'd0;

    string      method_names [5] = '{"GET", "POST", "HEAD", "PUT", "DELETE"};
    string      version_names[2] = '{"HTTP/1.0", "HTTP/1.1"};

    t_result    tags_due[$];
    t_result    step_tags[$];
    int         errors;

    t_phase     phase;
    t_line_part line_part;
    logic [4:0] method_live;
    int         method_len;
    logic [1:0] version_live;
    int         version_len;
    bit         colon_seen;
    bit         cr_held;
    logic [2:0] method_code;

    function void restart();
        phase        = PH_REQ_LINE;
        line_part    = LP_METHOD;
        method_live  = 5'h1F;
        method_len   = 0;
        version_live = 2'b11;
        version_len  = 0;
        colon_seen   = 1'b0;
        cr_held      = 1'b0;
        method_code  = NO_METHOD;
    endfunction

    function void push_tag(logic [7:0] b, logic [3:0] part, logic [2:0] status,
                           logic [1:0] version);
        t_result t;
        t.byte_out     = b;
        t.part         = part;
        t.method_code  = method_code;
        t.version_code = version;
        t.status       = status;
        t.last         = 1'b0;
        step_tags.push_back(t);
    endfunction

    function void reject(logic [7:0] b);
        push_tag(b, PART_UNPARSED, ST_REJECT, VER_NONE);
        phase = PH_REJECTED;
    endfunction

    // Tags one content byte of the current line (never a held CR decision).
    function void tag_content(logic [7:0] b);
        logic [4:0] live;
        logic [1:0] vlive;
        logic [2:0] code;
        if (phase == PH_HEADERS) begin
            if (colon_seen) begin
                push_tag(b, PART_HVALUE, ST_ONGOING, VER_NONE);
            end else if (b == CH_COLON) begin
                colon_seen = 1'b1;
                push_tag(b, PART_SEP, ST_ONGOING, VER_NONE);
            end else begin
                push_tag(b, PART_HNAME, ST_ONGOING, VER_NONE);
            end
            return;
        end
        case (line_part)
            LP_METHOD: begin
                if (b == CH_SP) begin
                    code = NO_METHOD;
                    for (int i = 0; i < 5; i++)
                        if (method_live[i] && method_names[i].len() == method_len)
                            code = 3'(i + 1);
                    if (code == NO_METHOD) begin
                        reject(b);
                    end else begin
                        method_code = code;
                        line_part   = LP_PATH;
                        push_tag(b, PART_SEP, ST_ONGOING, VER_NONE);
                    end
                end else begin
                    live = '0;
                    for (int i = 0; i < 5; i++)
                        if (method_live[i] && method_len < method_names[i].len()
                            && method_names[i][method_len] == b)
                            live[i] = 1'b1;
                    method_live = live;
                    if (live == '0) begin
                        reject(b);
                    end else begin
                        method_len++;
                        push_tag(b, PART_METHOD, ST_ONGOING, VER_NONE);
                    end
                end
            end
            LP_PATH, LP_QUERY: begin
                if (b == CH_SP) begin
                    line_part = LP_VERSION;
                    push_tag(b, PART_SEP, ST_ONGOING, VER_NONE);
                end else if (b == CH_QMARK && line_part == LP_PATH) begin
                    line_part = LP_QUERY;
                    push_tag(b, PART_SEP, ST_ONGOING, VER_NONE);
                end else begin
                    push_tag(b, (line_part == LP_PATH) ? PART_PATH : PART_QUERY,
                             ST_ONGOING, VER_NONE);
                end
            end
            default: begin
                vlive = '0;
                for (int i = 0; i < 2; i++)
                    if (version_live[i] && version_len < version_names[i].len()
                        && version_names[i][version_len] == b)
                        vlive[i] = 1'b1;
                version_live = vlive;
                if (vlive == '0) begin
                    reject(b);
                end else begin
                    version_len++;
                    push_tag(b, PART_VERSION, ST_ONGOING, VER_NONE);
                end
            end
        endcase
    endfunction

    // A held CR followed by LF closes the current line.
    function void end_line();
        push_tag(CH_CR, PART_LINE_END, ST_ONGOING, VER_NONE);
        if (phase == PH_REQ_LINE) begin
            if (line_part == LP_VERSION && version_len == version_names[0].len()
                && version_live != '0) begin
                phase      = PH_HEADERS;
                colon_seen = 1'b0;
                push_tag(CH_LF, PART_LINE_END, ST_REQ_OK,
                         version_live[1] ? VER_1_1 : VER_1_0);
            end else begin
                phase = PH_REJECTED;
                push_tag(CH_LF, PART_LINE_END, ST_REJECT, VER_NONE);
            end
        end else if (colon_seen) begin
            colon_seen = 1'b0;
            push_tag(CH_LF, PART_LINE_END, ST_HDR_DONE, VER_NONE);
        end else begin
            phase = PH_COMPLETE;
            push_tag(CH_LF, PART_LINE_END, ST_HEAD_END, VER_NONE);
        end
    endfunction

    function void take_byte(logic [7:0] b);
        if (phase == PH_COMPLETE || phase == PH_REJECTED)
            push_tag(b, PART_UNPARSED, ST_ONGOING, VER_NONE);
        else if (b == CH_CR)
            cr_held = 1'b1;
        else
            tag_content(b);
    endfunction

    // Called for every accepted request transaction.
    function void note_byte(logic kind, logic [7:0] b);
        t_result t;
        step_tags.delete();
        if (kind == KIND_RESTART) begin
            restart();
            return;
        end
        if ((phase == PH_REQ_LINE || phase == PH_HEADERS) && cr_held) begin
            cr_held = 1'b0;
            if (b == CH_LF) begin
                end_line();
            end else begin
                tag_content(CH_CR);
                take_byte(b);
            end
        end else begin
            cr_held = 1'b0;
            take_byte(b);
        end
        if (step_tags.size() > 0) begin
            t = step_tags.pop_back();
            t.last = 1'b1;
            step_tags.push_back(t);
        end
        foreach (step_tags[i])
            tags_due.push_back(step_tags[i]);
    endfunction

    // Called for every accepted output transaction.
    function void check_tag(t_result got);
        t_result want;
        if (tags_due.size() == 0) begin
            $error("unexpected tagged byte: byte_out %0d part %0d status %0d",
                   got.byte_out, got.part, got.status);
            errors++;
            return;
        end
        want = tags_due.pop_front();
        if (got.byte_out !== want.byte_out) begin
            $error("byte_out: expected %0d, actual %0d", want.byte_out, got.byte_out);
            errors++;
        end
        if (got.part !== want.part) begin
            $error("part: expected %0d, actual %0d", want.part, got.part);
            errors++;
        end
        if (got.method_code !== want.method_code) begin
            $error("method_code: expected %0d, actual %0d", want.method_code,
                   got.method_code);
            errors++;
        end
        if (got.version_code !== want.version_code) begin
            $error("version_code: expected %0d, actual %0d", want.version_code,
                   got.version_code);
            errors++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            errors++;
        end
    endfunction
endclass

module tb_http_request_head_tokenizer_top;

    // Run shape. The watchdog limit is far above the longest legal quiet
    // stretch, which is the long receiver hold-off plus a sender gap.
    localparam int TOTAL_ITEMS    = 430;
    localparam int QUIET_ITEMS    = 60;
    localparam int HOLD_AT_ITEM   = 150;
    localparam int LONG_HOLD      = 64;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 1000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hrht_in_if  req_if ();
    hrht_out_if tok_if ();

    http_request_head_tokenizer_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_tok   (tok_if)
    );

    // 8 ns clock period.
    always #4 i_clk = ~i_clk;

    tag_scoreboard sb;

    logic [7:0] req_bytes[$];   // bytes of the request being sent
    int         sent = 0;        // accepted request transactions
    int         idle_cycles = 0; // cycles since the last accepted transaction
    bit         quiet = 1'b0;    // no idling on either side once set
    bit         hold_req = 1'b0; // asks the receiver for one long hold-off

    // ------------------------------------------------------------------------
    // Monitor. Both channels are sampled at the rising edge, before any
    // nonblocking update of that edge lands, so the order of processes within
    // the time step does not matter. The input transaction is noted before the
    // output is checked; since results pass through the registered queue before
    // they leave, an expectation is always in place when its result shows up.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                sb.note_byte(req_if.kind, req_if.data_byte);
            if (tok_if.valid && tok_if.ready) begin
                got.byte_out     = tok_if.byte_out;
                got.part         = tok_if.part;
                got.method_code  = tok_if.method_code;
                got.version_code = tok_if.version_code;
                got.status       = tok_if.status;
                got.last         = tok_if.last;
                sb.check_tag(got);
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (tok_if.valid && tok_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("tb_http_request_head_tokenizer_top NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. Ready runs in random stretches, broken by random stalls. When
    // asked, it holds ready low for one long stretch counted here, while the
    // sender keeps offering bytes; the result queue then fills and the block
    // has to drop its own ready. Once the run goes quiet the receiver never
    // stalls.
    // ------------------------------------------------------------------------
    initial begin
        tok_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                tok_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                tok_if.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                tok_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Offers one transaction and returns at the edge that accepts it. Ready is
    // read right at the edge, which is its value before that edge.
    task automatic send_item(logic kind, logic [7:0] b);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.kind      <= kind;
        req_if.data_byte <= b;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(KIND_DATA, s[i]);
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            req_bytes.push_back(s[i]);
    endfunction

    // Random printable characters from lowest up to '~'. Now and then a lone
    // CR slips in; the character after it is never LF, so it cannot end the
    // line and must come back out as ordinary content.
    function automatic void add_field(int max_len, int lowest);
        repeat ($urandom_range(0, max_len)) begin
            if ($urandom_range(0, 15) == 0)
                req_bytes.push_back(CH_CR);
            req_bytes.push_back(8'($urandom_range(lowest, 126)));
        end
    endfunction

    // ------------------------------------------------------------------------
    // Builds one request head. Most are well formed with random paths, queries
    // and headers, since only a good request line reaches the header phase.
    // The rest carry a truncated or unknown method, a damaged or short
    // version, a header line without a colon, a single randomly overwritten
    // byte, or are plain noise. Random bytes after the head land in the
    // complete or rejected phase and come back unparsed.
    // ------------------------------------------------------------------------
    function automatic void build_request();
        int    pick;
        int    base;
        string name;
        req_bytes.delete();
        if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(5, 15))
                req_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end

        pick = $urandom_range(0, 19);
        name = sb.method_names[$urandom_range(0, 4)];
        if (pick < 16)
            add_text(name);
        else if (pick < 18)
            add_text(name.substr(0, $urandom_range(0, name.len() - 2)));
        else
            repeat ($urandom_range(1, 3))
                req_bytes.push_back(8'($urandom_range(0, 255)));
        req_bytes.push_back(CH_SP);

        req_bytes.push_back("/");
        add_field(6, 33);
        if ($urandom_range(0, 1) == 1) begin
            req_bytes.push_back(CH_QMARK);
            add_field(6, 33);
        end
        req_bytes.push_back(CH_SP);

        pick = $urandom_range(0, 9);
        name = sb.version_names[$urandom_range(0, 1)];
        base = req_bytes.size();
        if (pick < 8) begin
            add_text(name);
        end else if (pick == 8) begin
            add_text(name.substr(0, $urandom_range(0, name.len() - 2)));
        end else begin
            add_text(name);
            req_bytes[base + $urandom_range(0, name.len() - 1)] = 8'($urandom_range(0, 255));
        end
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_LF);

        repeat ($urandom_range(0, 3)) begin
            req_bytes.push_back(8'($urandom_range(33, 126)));
            add_field(5, 33);
            if ($urandom_range(0, 7) != 0)
                req_bytes.push_back(CH_COLON);
            add_field(8, 32);
            req_bytes.push_back(CH_CR);
            req_bytes.push_back(CH_LF);
        end
        // The head ends at a line without a colon, usually the empty one.
        if ($urandom_range(0, 7) == 0)
            add_field(4, 59);
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_LF);

        repeat ($urandom_range(0, 3))
            req_bytes.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0)
            req_bytes[$urandom_range(0, req_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence: reset, a short directed part, then random requests, each
    // opened by a restart transaction with a random don't-care byte.
    // ------------------------------------------------------------------------
    initial begin
        bit held;
        held             = 1'b0;
        sb               = new;
        sb.errors        = 0;
        sb.restart();
        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.kind      <= KIND_DATA;
        req_if.data_byte <= 8'h00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A space after an unfinished method rejects the line; the top byte
        // value that follows is then unparsed.
        send_text("GE ");
        send_item(KIND_DATA, 8'hFF);
        // A method byte that fits no method rejects at once; a zero byte
        // follows in the rejected phase.
        send_item(KIND_RESTART, 8'hFF);
        send_item(KIND_DATA, "X");
        send_item(KIND_DATA, 8'h00);
        // Query separator as the first path byte, then a line that ends at
        // CR LF before its version is complete.
        send_item(KIND_RESTART, 8'h00);
        send_text("PUT ? H");
        send_item(KIND_DATA, CH_CR);
        send_item(KIND_DATA, CH_LF);
        // A restart drops a held CR without any output.
        send_item(KIND_RESTART, 8'h55);
        send_text("G");
        send_item(KIND_DATA, CH_CR);
        send_item(KIND_RESTART, 8'hAA);

        while (sent < TOTAL_ITEMS) begin
            if (!held && sent >= HOLD_AT_ITEM) begin
                held     = 1'b1;
                hold_req = 1'b1;
            end
            if (sent >= TOTAL_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            build_request();
            send_item(KIND_RESTART, 8'($urandom_range(0, 255)));
            foreach (req_bytes[i])
                send_item(KIND_DATA, req_bytes[i]);
        end
        req_if.valid <= 1'b0;

        // Let every predicted byte come out, then idle for DRAIN_CYCLES to catch
        // anything extra. The watchdog covers a block that stops short.
        while (sb.tags_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        if (sb.errors == 0 && sb.tags_due.size() == 0)
            $display("tb_http_request_head_tokenizer_top OK");
        else
            $display("tb_http_request_head_tokenizer_top NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/hrht_pkg.sv
hw/rtl/hrht_ifs.sv
hw/rtl/hrht_core.sv
hw/rtl/hrht_rfifo.sv
hw/rtl/http_request_head_tokenizer_top.sv
bench/tb_http_request_head_tokenizer_top.sv
